// ----- rtl/adcma_pkg.sv -----
// Package for the converter moving-average block: field widths, bit positions,
// item kinds and the ring write request type.
// No dependencies.
`default_nettype none

package adcma_pkg;

  // Raw converter word layout
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned SAMPLE_LSB = 4;
  localparam int unsigned DONE_BIT   = 31;

  // Output item padded to whole bytes
  localparam int unsigned AVG_TDATA_W = 16;

  // Item kinds carried in tuser
  typedef enum logic {
    OP_RESULT  = 1'b0,
    OP_REQUEST = 1'b1
  } adcma_op_e;

  // Write request into the sample ring
  typedef struct packed {
    logic                en;
    logic [SAMPLE_W-1:0] sample;
  } adcma_ring_wr_t;

endpackage : adcma_pkg

`default_nettype wire

// ----- rtl/adcma_ring.sv -----
// Sample ring: WINDOW-deep store with write pointer, per-entry valid bits and
// a registered read of the oldest entry. Depends on adcma_pkg.
`default_nettype none

module adcma_ring
  import adcma_pkg::*;
#(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire adcma_ring_wr_t      wr_i,
  output logic      [SAMPLE_W-1:0] oldest_o
);

  localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [SAMPLE_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]   valid_q;
  logic [PTR_W-1:0]    wp_q, wp_d;
  logic [SAMPLE_W-1:0] rd_data_q;
  logic [SAMPLE_W-1:0] byp_data_q;
  logic                byp_q;
  logic                rd_valid_q;

  // Advance the write pointer, wrapping at the window size
  always_comb begin
    wp_d = wp_q;
    if (wr_i.en) begin
      if (wp_q == PTR_W'(WINDOW - 1)) begin
        wp_d = '0;
      end else begin
        wp_d = wp_q + PTR_W'(1);
      end
    end
  end

  // Pointer, valid bits and read select
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      valid_q    <= '0;
      byp_q      <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      wp_q <= wp_d;
      if (wr_i.en) begin
        valid_q[wp_q] <= 1'b1;
      end
      byp_q      <= wr_i.en && (wp_d == wp_q);
      rd_valid_q <= valid_q[wp_d];
    end
  end

  // Write the new sample, prefetch the entry at the next pointer
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wp_q] <= wr_i.sample;
    end
    rd_data_q  <= mem[wp_d];
    byp_data_q <= wr_i.sample;
  end

  // Unwritten entries read as zero; a one-deep ring sees its own write
  assign oldest_o = byp_q      ? byp_data_q :
                    rd_valid_q ? rd_data_q  : '0;

endmodule : adcma_ring

`default_nettype wire

// ----- rtl/adcma_div.sv -----
// Divide the window sum by WINDOW through a constant reciprocal multiply,
// exact for every sum below 2**SUM_W. Depends on adcma_pkg.
`default_nettype none

module adcma_div
  import adcma_pkg::*;
#(
  parameter int unsigned WINDOW = 16,
  parameter int unsigned SUM_W  = 16
) (
  input  wire logic [SUM_W-1:0]    sum_i,
  output logic      [SAMPLE_W-1:0] average_o
);

  localparam int unsigned SHIFT_L = (WINDOW > 1) ? $clog2(WINDOW) : 0;
  localparam int unsigned K       = SUM_W + SHIFT_L;
  localparam longint unsigned RECIP =
    ((64'd1 << K) + longint'(WINDOW) - 64'd1) / longint'(WINDOW);
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = 2 * SUM_W + 1;

  logic [RECIP_W-1:0] recip;
  logic [PROD_W-1:0]  prod;

  // Multiply by the rounded-up reciprocal and drop the fraction
  assign recip     = RECIP_W'(RECIP);
  assign prod      = PROD_W'(sum_i) * PROD_W'(recip);
  assign average_o = prod[K +: SAMPLE_W];

endmodule : adcma_div

`default_nettype wire

// ----- rtl/adc_moving_average.sv -----
// Top level of the converter moving-average block: input register, sum update,
// divide stage and output register. Depends on adcma_pkg, adcma_ring, adcma_div.
`default_nettype none

//  channel   dir  signals                          contents
//  s_axis    in   tvalid tready tdata[31:0] tuser  result_word; tuser = op
//  m_axis    out  tvalid tready tdata[15:0]        average in bits 11:0, rest zero
//
//  One item is accepted per cycle when the output side keeps up.
//  A request-served sample reaches m_axis after it is accepted through the
//  input register, the sum update into the divide register and the reciprocal
//  multiply into the output register.
//  Reset clears the ring through its valid bits at once; no clearing pass.
//  A stall on m_axis backs up through the divide and input registers; only
//  items that give a result wait for room downstream.

module adc_moving_average
  import adcma_pkg::*;
#(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [WORD_W-1:0]      s_axis_tdata,  // [31:0] result_word
  input  wire logic                   s_axis_tuser,  // [0] op
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic      [AVG_TDATA_W-1:0] m_axis_tdata   // [11:0] average, [15:12] zero
);

  localparam int unsigned SUM_W   = $clog2(WINDOW * 4095 + 1);
  localparam int unsigned SUM_MAX = WINDOW * 4095;

  // Input register
  logic                i_valid_q;
  adcma_op_e           i_op_q;
  logic                i_done_q;
  logic [SAMPLE_W-1:0] i_sample_q;

  // State
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                pend_q, pend_d;

  // Divide and output registers
  logic                d_valid_q;
  logic [SUM_W-1:0]    d_sum_q;
  logic                o_valid_q;
  logic [SAMPLE_W-1:0] o_avg_q;

  logic                i_take;
  logic                i_emit;
  logic                i_adv;
  logic                d_ready;
  logic                o_ready;
  logic [SAMPLE_W-1:0] oldest;
  logic [SAMPLE_W-1:0] quotient;
  adcma_ring_wr_t      ring_wr;

  // Handshake chain
  assign o_ready       = !o_valid_q || m_axis_tready;
  assign d_ready       = !d_valid_q || o_ready;
  assign i_take        = i_valid_q && (i_op_q == OP_RESULT) && i_done_q;
  assign i_emit        = i_take && pend_q;
  assign i_adv         = i_valid_q && (!i_emit || d_ready);
  assign s_axis_tready = !i_valid_q || i_adv;

  // Capture the incoming item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      i_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      i_op_q     <= adcma_op_e'(s_axis_tuser);
      i_done_q   <= s_axis_tdata[DONE_BIT];
      i_sample_q <= s_axis_tdata[SAMPLE_LSB +: SAMPLE_W];
    end
  end

  // Ring of past samples
  assign ring_wr.en     = i_adv && i_take;
  assign ring_wr.sample = i_sample_q;

  adcma_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (ring_wr),
    .oldest_o (oldest)
  );

  // Update running sum and request flag
  always_comb begin
    sum_d  = sum_q;
    pend_d = pend_q;
    if (i_adv) begin
      if (i_op_q == OP_REQUEST) begin
        pend_d = 1'b1;
      end else if (i_done_q) begin
        sum_d  = sum_q - SUM_W'(oldest) + SUM_W'(i_sample_q);
        pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      pend_q <= pend_d;
    end
  end

  // Divide stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (i_adv && i_emit) begin
      d_valid_q <= 1'b1;
    end else if (o_ready) begin
      d_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (i_adv && i_emit) begin
      d_sum_q <= sum_d;
    end
  end

  adcma_div #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_div (
    .sum_i     (d_sum_q),
    .average_o (quotient)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (d_valid_q && o_ready) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_valid_q && o_ready) begin
      o_avg_q <= quotient;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = AVG_TDATA_W'(o_avg_q);

  // A served request always lands in the divide stage and clears the flag
  a_emit_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (i_adv && i_emit) |=> (d_valid_q && !pend_q))
    else $error("served request did not reach the divide stage");

  // The running sum never exceeds a full window of maximum samples
  a_sum_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= SUM_W'(SUM_MAX))
    else $error("window sum out of range");

  // A blocked divide stage keeps its sum
  a_div_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (d_valid_q && !o_ready) |=> (d_valid_q && $stable(d_sum_q)))
    else $error("divide stage lost its item under stall");

  // An item with nothing to emit never waits in the input register
  a_no_needless_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (i_valid_q && !i_emit) |-> s_axis_tready)
    else $error("input stalled without a result to deliver");

endmodule : adc_moving_average

`default_nettype wire
